// File: hdl/scpr_pkg.sv
// Shared constants and the CRC step of the servo command packet receiver.
// Used by servo_command_packet_receiver and scpr_checker; no dependencies.
`default_nettype none

package scpr_pkg;

  // frame framing bytes and CRC polynomial
  localparam logic [7:0]  HDR0         = 8'hAA;
  localparam logic [7:0]  HDR1         = 8'hBB;
  localparam logic [7:0]  CHECK_BYPASS = 8'hFF;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  // default frame size limit (whole frame, header through check byte)
  localparam int FRAME_BYTES_MAX_DEF = 64;

  // fixed byte positions inside a frame
  localparam int POS_HDR0     = 0;
  localparam int POS_HDR1     = 1;
  localparam int POS_RESERVED = 2;
  localparam int POS_LENGTH   = 3;
  localparam int POS_INSTR    = 4;
  localparam int POS_ADDR     = 5;
  localparam int POS_DATA     = 6;

  // smallest legal length byte, and the bytes of a frame not counted by it
  localparam logic [7:0] LEN_MIN      = 8'd3;
  localparam int         LEN_OVERHEAD = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_OP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_OP = 2'd2;

  localparam logic [7:0] RESERVED_RST = 8'h00;
  localparam logic [7:0] READ_OP_RST  = 8'h02;
  localparam logic [7:0] WRITE_OP_RST = 8'h03;

  // result kinds and status codes
  localparam logic KIND_HDR   = 1'b0;
  localparam logic KIND_DATA  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/servo_command_packet_receiver.sv
// Servo command packet receiver: byte parser, CRC check, payload memory and result emitter.
// Depends on scpr_pkg.
`default_nettype none

// Takes one received byte per request and hunts for frames AA BB, reserved, L, instruction,
// address, L-3 data bytes, check byte. The check byte must match the low byte of a CRC-16
// (0x8005, MSB first, init 0) over the frame or be FF. While parsing, every offered byte
// is taken; only the check byte waits for the output register to be free. A read frame or a
// failed frame gives one header result. A good write frame gives a header result and then
// one result per data byte; data bytes come back out of the payload memory through a memory
// read and then an output register load, and input is stalled during that emission. Frames
// with L below 3 or longer than FRAME_BYTES_MAX bytes are dropped.
module servo_command_packet_receiver #(
  parameter int FRAME_BYTES_MAX = scpr_pkg::FRAME_BYTES_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [scpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata,
  // received bytes
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic                                out_status,
  output logic                                out_is_write,
  output logic [7:0]                          out_start_address,
  output logic [7:0]                          out_count,
  output logic [7:0]                          out_data_byte,
  output logic                                out_last
);

  localparam int PW = $clog2(FRAME_BYTES_MAX);

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_FETCH = 3'b010,
    S_LOAD  = 3'b100
  } state_t;

  // configuration registers
  logic [7:0] reserved_r, rd_op_r, wr_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= scpr_pkg::RESERVED_RST;
      rd_op_r    <= scpr_pkg::READ_OP_RST;
      wr_op_r    <= scpr_pkg::WRITE_OP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scpr_pkg::REG_RESERVED: reserved_r <= cfg_wdata;
        scpr_pkg::REG_READ_OP:  rd_op_r    <= cfg_wdata;
        scpr_pkg::REG_WRITE_OP: wr_op_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          is_wr_r, is_wr_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;

  // output payload registers
  logic       out_kind_r, out_status_r, out_is_write_r, out_last_r;
  logic [7:0] out_addr_r, out_count_r, out_data_r;

  // payload memory
  logic [7:0]    mem [FRAME_BYTES_MAX];
  logic [7:0]    mem_q;
  logic          mem_we, rd_en;
  logic [PW-1:0] mem_wa;

  logic       in_acc, out_free, load_hdr, load_data;
  logic [8:0] pos9, lim9;
  logic       in_data, at_check;
  logic [7:0] b, ndata, cnt;
  logic       crc_ok, hdr_last, data_last;
  logic [15:0] crc_b;

  assign b        = in_rx_byte;
  assign out_free = !out_valid_r || !out_stall;
  assign pos9     = 9'(pos_r);
  assign lim9     = {1'b0, len_r} + 9'(scpr_pkg::LEN_MIN);
  assign in_data  = (pos9 >= 9'(scpr_pkg::POS_DATA)) && (pos9 < lim9);
  assign at_check = (pos9 >= 9'(scpr_pkg::POS_DATA)) && !(pos9 < lim9);
  // the check byte is held off until the header result has somewhere to go
  assign in_stall = (state_r != S_RUN) || (at_check && !out_free);
  assign in_acc   = in_valid && !in_stall;
  assign crc_b    = scpr_pkg::crc_feed(crc_r, b);

  assign ndata     = len_r - scpr_pkg::LEN_MIN;
  assign cnt       = is_wr_r ? ndata : ((ndata != 8'd0) ? first_r : 8'd0);
  assign crc_ok    = (b == crc_r[7:0]) || (b == scpr_pkg::CHECK_BYPASS);
  assign hdr_last  = !crc_ok || !is_wr_r || (ndata == 8'd0);
  assign data_last = (8'(k_r) + 8'd1) == ndata;
  assign mem_wa    = pos_r - PW'(scpr_pkg::POS_DATA);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    is_wr_nxt     = is_wr_r;
    addr_nxt      = addr_r;
    crc_nxt       = crc_r;
    first_nxt     = first_r;
    k_nxt         = k_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    load_hdr      = 1'b0;
    load_data     = 1'b0;
    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (pos_r == PW'(scpr_pkg::POS_HDR0)) begin
            if (b == scpr_pkg::HDR0) begin
              crc_nxt = scpr_pkg::crc_feed(16'h0000, b);
              pos_nxt = PW'(scpr_pkg::POS_HDR1);
            end
          end else if (pos_r == PW'(scpr_pkg::POS_HDR1)) begin
            crc_nxt = crc_b;
            pos_nxt = (b == scpr_pkg::HDR1) ? PW'(scpr_pkg::POS_RESERVED)
                                             : PW'(scpr_pkg::POS_HDR0);
          end else if (pos_r == PW'(scpr_pkg::POS_RESERVED)) begin
            crc_nxt = crc_b;
            pos_nxt = (b == reserved_r) ? PW'(scpr_pkg::POS_LENGTH)
                                        : PW'(scpr_pkg::POS_HDR0);
          end else if (pos_r == PW'(scpr_pkg::POS_LENGTH)) begin
            if (b < scpr_pkg::LEN_MIN ||
                ({1'b0, b} + 9'(scpr_pkg::LEN_OVERHEAD)) > 9'(FRAME_BYTES_MAX)) begin
              pos_nxt = PW'(scpr_pkg::POS_HDR0);
            end else begin
              len_nxt = b;
              crc_nxt = crc_b;
              pos_nxt = PW'(scpr_pkg::POS_INSTR);
            end
          end else if (pos_r == PW'(scpr_pkg::POS_INSTR)) begin
            // an instruction matching both opcodes counts as a read
            if (b == rd_op_r || b == wr_op_r) begin
              is_wr_nxt = (b != rd_op_r);
              crc_nxt   = crc_b;
              pos_nxt   = PW'(scpr_pkg::POS_ADDR);
            end else begin
              pos_nxt = PW'(scpr_pkg::POS_HDR0);
            end
          end else if (pos_r == PW'(scpr_pkg::POS_ADDR)) begin
            addr_nxt = b;
            crc_nxt  = crc_b;
            pos_nxt  = PW'(scpr_pkg::POS_DATA);
          end else if (in_data) begin
            mem_we  = 1'b1;
            if (pos_r == PW'(scpr_pkg::POS_DATA)) begin
              first_nxt = b;
            end
            crc_nxt = crc_b;
            pos_nxt = pos_r + PW'(1);
          end else begin
            // check byte
            load_hdr = 1'b1;
            pos_nxt  = PW'(scpr_pkg::POS_HDR0);
            if (!hdr_last) begin
              k_nxt     = '0;
              state_nxt = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load_data = 1'b1;
          k_nxt     = k_r + PW'(1);
          state_nxt = data_last ? S_RUN : S_FETCH;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    if (load_hdr || load_data) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      pos_r       <= '0;
      len_r       <= '0;
      is_wr_r     <= 1'b0;
      addr_r      <= '0;
      crc_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      is_wr_r     <= is_wr_nxt;
      addr_r      <= addr_nxt;
      crc_r       <= crc_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    if (load_hdr) begin
      out_kind_r     <= scpr_pkg::KIND_HDR;
      out_status_r   <= crc_ok ? scpr_pkg::STATUS_OK : scpr_pkg::STATUS_BAD;
      out_is_write_r <= is_wr_r;
      out_addr_r     <= addr_r;
      out_count_r    <= cnt;
      out_data_r     <= 8'h00;
      out_last_r     <= hdr_last;
    end else if (load_data) begin
      // remaining fields repeat the header result
      out_kind_r <= scpr_pkg::KIND_DATA;
      out_data_r <= mem_q;
      out_last_r <= data_last;
    end
  end

  // writes happen only while parsing, reads only while emitting; the input stall
  // during emission keeps the next frame from overwriting unread bytes
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= b;
    end
    if (rd_en) begin
      mem_q <= mem[k_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_is_write      = out_is_write_r;
  assign out_start_address = out_addr_r;
  assign out_count         = out_count_r;
  assign out_data_byte     = out_data_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// File: hdl/scpr_checker.sv
// Port-level checks for servo_command_packet_receiver, attached by bind.
// Depends on scpr_pkg.
`default_nettype none

module scpr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_kind,
  input wire logic       out_status,
  input wire logic       out_is_write,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // data results only follow a good write frame
  a_data_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scpr_pkg::KIND_DATA |->
      out_status == scpr_pkg::STATUS_OK && out_is_write)
    else $error("data result outside a good write frame");

  // a failed check gives a single header result
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == scpr_pkg::STATUS_BAD |->
      out_last && out_kind == scpr_pkg::KIND_HDR && out_data_byte == 8'h00)
    else $error("check failure not a single header result");

  // a header that is not last opens a write frame with data to follow
  a_hdr_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scpr_pkg::KIND_HDR && !out_last |->
      out_is_write && out_status == scpr_pkg::STATUS_OK)
    else $error("open header result without a good write frame");

endmodule

bind servo_command_packet_receiver scpr_checker u_scpr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_status    (out_status),
  .out_is_write  (out_is_write),
  .out_data_byte (out_data_byte),
  .out_last      (out_last)
);

`default_nettype wire
